// ----- hw/rtl/u7u8_pkg.sv -----
// Shared types, character codes, base64 decoding and UTF-8 encoding helpers for the UTF-7 to UTF-8 decoder.
package u7u8_pkg;

   localparam logic [6:0] CHAR_PLUS  = 7'h2b;
   localparam logic [6:0] CHAR_MINUS = 7'h2d;
   localparam logic [6:0] CHAR_SLASH = 7'h2f;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [6:0] char_in;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_of_run;
   } rsp_type;

   // Work handed from the front to the back: up to two code units and one raw character.
   typedef struct packed {
      logic        unit0_valid;
      logic [15:0] unit0;
      logic        unit1_valid;
      logic [15:0] unit1;
      logic        char_valid;
      logic [6:0]  char_code;
   } job_type;

   typedef struct packed {
      logic       is_b64;
      logic [5:0] value;
   } b64_type;

   typedef enum logic [1:0] {
      SEG_UNIT0,
      SEG_UNIT1,
      SEG_CHAR
   } seg_type;

   function automatic b64_type b64_decode(input logic [6:0] c);
      b64_type r;
      r.is_b64 = 1'b1;
      r.value  = '0;
      if (c >= 7'h41 && c <= 7'h5a) begin
         r.value = 6'(c - 7'h41);
      end else if (c >= 7'h61 && c <= 7'h7a) begin
         r.value = 6'(c - 7'h61 + 7'd26);
      end else if (c >= 7'h30 && c <= 7'h39) begin
         r.value = 6'(c - 7'h30 + 7'd52);
      end else if (c == CHAR_PLUS) begin
         r.value = 6'd62;
      end else if (c == CHAR_SLASH) begin
         r.value = 6'd63;
      end else begin
         r.is_b64 = 1'b0;
      end
      return r;
   endfunction

   // Number of UTF-8 bytes for one 16-bit unit: 1, 2 or 3.
   function automatic logic [1:0] unit_len(input logic [15:0] u);
      logic [1:0] n;
      if (u < 16'h0080) begin
         n = 2'd1;
      end else if (u < 16'h0800) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

   function automatic logic [7:0] unit_byte(input logic [15:0] u, input logic [1:0] idx);
      logic [7:0] b;
      logic [1:0] n;
      n = unit_len(u);
      b = u[7:0];
      if (n == 2'd2) begin
         b = (idx == 2'd0) ? {3'b110, u[10:6]} : {2'b10, u[5:0]};
      end else if (n == 2'd3) begin
         unique case (idx)
            2'd0:    b = {4'b1110, u[15:12]};
            2'd1:    b = {2'b10, u[11:6]};
            default: b = {2'b10, u[5:0]};
         endcase
      end
      return b;
   endfunction

endpackage

// ----- hw/rtl/utf7_to_utf8_decoder_top.sv -----
// Top level of the UTF-7 to UTF-8 decoder: front end, job queue and byte serializer.
//
// Each request beat carries one 7-bit character of UTF-7 text, or an end-of-text
// marker that flushes any partial base64 group and returns the decoder to its reset
// state. Each response beat carries one UTF-8 byte; last_of_run marks the final byte
// caused by a given request. A request causes zero to seven bytes; one that causes
// none (a '+', a base64 sextet that does not complete a group) produces no beat.
// Rate: the front end takes one request per cycle whenever its four-entry job queue
// is not full, so characters that map to at most one byte stream through at one per
// cycle while rsp_ready holds. The serializer emits one byte per cycle unless the
// response port stalls; the queue absorbs bursts of multi-byte runs. With the queue
// empty and the output register free, a request's first byte is written to the job
// queue, then to the output register, and then shows on the response port. Surrogate
// halves are encoded individually as three-byte sequences and never paired.
module utf7_to_utf8_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  u7u8_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u7u8_pkg::rsp_type rsp_data
);
   import u7u8_pkg::*;

   logic    job_push;
   job_type job_in;
   logic    job_pop;
   logic    job_valid;
   job_type job_head;
   logic    queue_full;

   // Classify each character and decide which units and raw bytes it releases.
   u7u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   // Hold pending jobs so the front end keeps taking characters during long runs.
   u7u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_head),
      .full       (queue_full)
   );

   // Expand each job into UTF-8 bytes, one beat per cycle unless the response port stalls, through an output register.
   u7u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/u7u8_front.sv -----
// Front end: accepts characters, tracks UTF-7 mode and sextet state, builds output jobs.
module u7u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  u7u8_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              job_push,
   output u7u8_pkg::job_type job_data
);
   import u7u8_pkg::*;

   logic        mode_ff, mode_in;
   logic        plus_ff, plus_in;
   logic [1:0]  count_ff, count_in;
   logic [17:0] acc_ff, acc_in;
   logic        phase_ff, phase_in;
   logic [7:0]  carried_ff, carried_in;

   logic        accept;
   logic        eot;
   logic [6:0]  c;
   logic        is_plus, is_minus;
   b64_type     b64;
   logic [1:0]  eff_count;
   logic [17:0] eff_acc;
   logic        eff_phase;
   logic [7:0]  eff_carried;
   logic        do_b64;
   logic        do_decode;
   logic [23:0] padded;
   logic [23:0] group;
   logic [15:0] u0, u1;
   logic        u1_nonzero;
   logic [7:0]  dec_carried;
   logic        dec_phase;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      eot      = req_data.end_of_text;
      c        = req_data.char_in;
      is_plus  = (c == CHAR_PLUS);
      is_minus = (c == CHAR_MINUS);
      b64      = b64_decode(c);

      // A pending '+' followed by a non-minus starts base64 from clean state.
      eff_count   = plus_ff ? 2'd0  : count_ff;
      eff_acc     = plus_ff ? '0    : acc_ff;
      eff_phase   = plus_ff ? 1'b0  : phase_ff;
      eff_carried = plus_ff ? 8'h00 : carried_ff;

      do_b64 = !eot && (plus_ff ? !is_minus : mode_ff);

      unique case (eff_count)
         2'd0:    padded = '0;
         2'd1:    padded = {eff_acc[5:0], 18'b0};
         2'd2:    padded = {eff_acc[11:0], 12'b0};
         default: padded = {eff_acc, 6'b0};
      endcase
      group = (do_b64 && b64.is_b64) ? {eff_acc, b64.value} : padded;

      if (eot) begin
         do_decode = mode_ff && (count_ff != 2'd0);
      end else begin
         do_decode = do_b64 && (b64.is_b64 ? (eff_count == 2'd3) : (eff_count != 2'd0));
      end

      if (!eff_phase) begin
         u0          = group[23:8];
         u1          = '0;
         u1_nonzero  = 1'b0;
         dec_carried = group[7:0];
         dec_phase   = 1'b1;
      end else begin
         u0          = {eff_carried, group[23:16]};
         u1          = group[15:0];
         u1_nonzero  = |group[15:0];
         dec_carried = 8'h00;
         dec_phase   = 1'b0;
      end

      job_data.unit0_valid = do_decode;
      job_data.unit0       = u0;
      job_data.unit1_valid = do_decode && u1_nonzero;
      job_data.unit1       = u1;
      job_data.char_valid  = !eot && ((plus_ff && is_minus) ||
                                      (do_b64 && !b64.is_b64 && !is_minus) ||
                                      (!plus_ff && !mode_ff && !is_plus));
      job_data.char_code   = (plus_ff && is_minus) ? CHAR_PLUS : c;

      job_push = accept && (job_data.unit0_valid || job_data.char_valid);

      mode_in    = mode_ff;
      plus_in    = plus_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      phase_in   = phase_ff;
      carried_in = carried_ff;
      if (accept) begin
         priority if (eot) begin
            mode_in    = 1'b0;
            plus_in    = 1'b0;
            count_in   = 2'd0;
            acc_in     = '0;
            phase_in   = 1'b0;
            carried_in = 8'h00;
         end else if (do_b64) begin
            plus_in = 1'b0;
            if (!b64.is_b64) begin
               mode_in    = 1'b0;
               count_in   = 2'd0;
               acc_in     = '0;
               phase_in   = 1'b0;
               carried_in = 8'h00;
            end else if (eff_count == 2'd3) begin
               mode_in    = 1'b1;
               count_in   = 2'd0;
               acc_in     = '0;
               phase_in   = dec_phase;
               carried_in = dec_carried;
            end else begin
               mode_in    = 1'b1;
               count_in   = eff_count + 2'd1;
               acc_in     = {eff_acc[11:0], b64.value};
               phase_in   = eff_phase;
               carried_in = eff_carried;
            end
         end else if (plus_ff) begin
            plus_in = 1'b0;
         end else begin
            plus_in = is_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         plus_ff    <= 1'b0;
         count_ff   <= 2'd0;
         acc_ff     <= '0;
         phase_ff   <= 1'b0;
         carried_ff <= 8'h00;
      end else begin
         mode_ff    <= mode_in;
         plus_ff    <= plus_in;
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         phase_ff   <= phase_in;
         carried_ff <= carried_in;
      end
   end

endmodule

// ----- hw/rtl/u7u8_queue.sv -----
// Small job queue between the decoder front end and the byte serializer.
module u7u8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u7u8_pkg::job_type push_data,
   input  logic              pop,
   output logic              head_valid,
   output u7u8_pkg::job_type head_data,
   output logic              full
);
   import u7u8_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;

   assign head_valid = (fill_ff != '0);
   assign full       = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- hw/rtl/u7u8_back.sv -----
// Back end: walks each job segment by segment and emits one UTF-8 byte per beat.
module u7u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  u7u8_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u7u8_pkg::rsp_type rsp_data
);
   import u7u8_pkg::*;

   seg_type     seg_ff, seg_in;
   logic [1:0]  sub_ff, sub_in;
   logic        in_job_ff, in_job_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   seg_type     first_seg, cur_seg, next_seg;
   logic        has_next;
   logic [1:0]  cur_sub;
   logic [15:0] cur_unit;
   logic [1:0]  cur_len;
   logic [7:0]  cur_byte;
   logic        seg_end;
   logic        last;
   logic        step;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      first_seg = job_data.unit0_valid ? SEG_UNIT0 :
                  (job_data.unit1_valid ? SEG_UNIT1 : SEG_CHAR);
      cur_seg   = in_job_ff ? seg_ff : first_seg;
      cur_sub   = in_job_ff ? sub_ff : 2'd0;
      cur_unit  = (cur_seg == SEG_UNIT1) ? job_data.unit1 : job_data.unit0;

      if (cur_seg == SEG_CHAR) begin
         cur_len  = 2'd1;
         cur_byte = {1'b0, job_data.char_code};
      end else begin
         cur_len  = unit_len(cur_unit);
         cur_byte = unit_byte(cur_unit, cur_sub);
      end
      seg_end = (cur_sub == cur_len - 2'd1);

      unique case (cur_seg)
         SEG_UNIT0: begin
            has_next = job_data.unit1_valid || job_data.char_valid;
            next_seg = job_data.unit1_valid ? SEG_UNIT1 : SEG_CHAR;
         end
         SEG_UNIT1: begin
            has_next = job_data.char_valid;
            next_seg = SEG_CHAR;
         end
         default: begin
            has_next = 1'b0;
            next_seg = SEG_CHAR;
         end
      endcase
      last = seg_end && !has_next;

      // Advance when a job is present and the output register is free or being drained.
      step    = job_valid && (!rsp_valid_ff || rsp_ready);
      job_pop = step && last;

      seg_in       = seg_ff;
      sub_in       = sub_ff;
      in_job_in    = in_job_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.utf8_byte = cur_byte;
         rsp_data_in.last_of_run = last;
         in_job_in             = !last;
         seg_in                = seg_end ? next_seg : cur_seg;
         sub_in                = seg_end ? 2'd0 : cur_sub + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_UNIT0;
         sub_ff       <= 2'd0;
         in_job_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         sub_ff       <= sub_in;
         in_job_ff    <= in_job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
